### rtl/core/drd_pkg.sv
// Shared constants, register codes and stage types of the detection row decoder.
// No dependencies; every other file of the block imports this package.
package drd_pkg;

    localparam int TENSOR_W        = 32;
    localparam int CLASS_COUNT     = 10;
    localparam int CLASS_W         = 4;
    localparam int COL_W           = 5;
    localparam int FIRST_CLASS_COL = 5;
    localparam int COL_MAX         = 31;

    localparam int THR_W = 17;
    localparam int INV_W = 24;
    localparam int PAD_W = 26;

    // Edge numerators carry one extra fraction bit (2^-17 px), products are
    // shifted down by 33 to whole pixels.
    localparam int NUM_W     = 35;
    localparam int PROD_W    = NUM_W + INV_W + 1;
    localparam int PIX_SHIFT = 33;
    localparam int PIX_Q_W   = PROD_W - PIX_SHIFT;
    localparam int PIX_W     = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 26;

    // Register reset values: 0.25 in Q1.16, 1.0 in Q8.16.
    localparam logic [THR_W-1:0] OBJ_THRESHOLD_RST   = THR_W'(16384);
    localparam logic [THR_W-1:0] SCORE_THRESHOLD_RST = THR_W'(16384);
    localparam logic [INV_W-1:0] INVERSE_SCALE_RST   = INV_W'(65536);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_OBJ_THRESHOLD   = 3'd0,
        REG_SCORE_THRESHOLD = 3'd1,
        REG_INVERSE_SCALE   = 3'd2,
        REG_PAD_X           = 3'd3,
        REG_PAD_Y           = 3'd4
    } drd_reg_e;

    typedef struct packed {
        logic [THR_W-1:0] obj_threshold;
        logic [THR_W-1:0] score_threshold;
        logic [INV_W-1:0] inverse_scale;
        logic [PAD_W-1:0] pad_x;
        logic [PAD_W-1:0] pad_y;
    } drd_cfg_t;

    // Kept row, handed from the accumulator to the box math.
    typedef struct packed {
        logic signed [NUM_W-1:0]    left_num;
        logic signed [NUM_W-1:0]    top_num;
        logic signed [NUM_W-1:0]    width_num;
        logic signed [NUM_W-1:0]    height_num;
        logic [CLASS_W-1:0]         class_index;
        logic signed [TENSOR_W-1:0] confidence;
    } drd_row_t;

endpackage

### rtl/core/drd_in_if.sv
// Input channel of the detection row decoder: one tensor word per handshake.
// Depends on drd_pkg.
interface drd_in_if;
    import drd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [TENSOR_W-1:0] tensor_value;
    logic                       last_in_row;

    modport source (output valid, output tensor_value, output last_in_row, input ready);
    modport sink   (input valid, input tensor_value, input last_in_row, output ready);

endinterface

### rtl/core/drd_out_if.sv
// Output channel of the detection row decoder: one decoded box per handshake.
// Depends on drd_pkg.
interface drd_out_if;
    import drd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [PIX_W-1:0]    box_left;
    logic signed [PIX_W-1:0]    box_top;
    logic [PIX_W-1:0]           box_width;
    logic [PIX_W-1:0]           box_height;
    logic [CLASS_W-1:0]         class_index;
    logic signed [TENSOR_W-1:0] confidence;

    modport source (output valid, output box_left, output box_top, output box_width,
                    output box_height, output class_index, output confidence,
                    input ready);
    modport sink   (input valid, input box_left, input box_top, input box_width,
                    input box_height, input class_index, input confidence,
                    output ready);

endinterface

### rtl/core/drd_row_acc.sv
// Row accumulator: column capture, running argmax, row-end keep test and edge
// numerators, registered into the row stage. Depends on drd_pkg, drd_in_if.
module drd_row_acc (
    input  logic              clk,
    input  logic              rst_n,
    drd_in_if.sink            tensor,
    input  drd_pkg::drd_cfg_t cfg,
    output logic              row_valid,
    output drd_pkg::drd_row_t row,
    input  logic              row_ready
);
    import drd_pkg::*;

    logic [COL_W-1:0]           col_reg, col_next;
    logic signed [TENSOR_W-1:0] cx_reg, cx_next, cx_upd;
    logic signed [TENSOR_W-1:0] cy_reg, cy_next, cy_upd;
    logic signed [TENSOR_W-1:0] w_reg, w_next, w_upd;
    logic signed [TENSOR_W-1:0] h_reg, h_next, h_upd;
    logic signed [TENSOR_W-1:0] obj_reg, obj_next, obj_upd;
    logic signed [TENSOR_W-1:0] best_reg, best_next, best_upd;
    logic [CLASS_W-1:0]         cls_reg, cls_next, cls_upd;
    logic [COL_W-1:0]           col_upd;

    logic     row_valid_reg, row_valid_next;
    drd_row_t row_reg, row_next;

    logic accept;
    logic in_class;
    logic keep;

    assign accept       = tensor.valid && tensor.ready;
    assign tensor.ready = !row_valid_reg || row_ready;

    // Apply the current word to the row state.
    always_comb
    begin
        cx_upd   = cx_reg;
        cy_upd   = cy_reg;
        w_upd    = w_reg;
        h_upd    = h_reg;
        obj_upd  = obj_reg;
        best_upd = best_reg;
        cls_upd  = cls_reg;
        in_class = ({1'b0, col_reg} >= (COL_W + 1)'(FIRST_CLASS_COL))
                && ({1'b0, col_reg} < (COL_W + 1)'(FIRST_CLASS_COL + CLASS_COUNT));
        unique case (col_reg)
            COL_W'(0): cx_upd  = tensor.tensor_value;
            COL_W'(1): cy_upd  = tensor.tensor_value;
            COL_W'(2): w_upd   = tensor.tensor_value;
            COL_W'(3): h_upd   = tensor.tensor_value;
            COL_W'(4): obj_upd = tensor.tensor_value;
            default:
            begin
                // first class column always loads; later ones only on a strict win
                if (in_class && (col_reg == COL_W'(FIRST_CLASS_COL)
                                 || tensor.tensor_value > best_reg))
                begin
                    best_upd = tensor.tensor_value;
                    cls_upd  = CLASS_W'(col_reg - COL_W'(FIRST_CLASS_COL));
                end
            end
        endcase
        col_upd = (col_reg == COL_W'(COL_MAX)) ? col_reg : col_reg + COL_W'(1);
    end

    // Row-end decision and edge numerators (units of 2^-17 px).
    always_comb
    begin
        keep = (col_reg >= COL_W'(FIRST_CLASS_COL))
            && ($signed({obj_upd[TENSOR_W-1], obj_upd})
                >= $signed({{(TENSOR_W + 1 - THR_W){1'b0}}, cfg.obj_threshold}))
            && ($signed({best_upd[TENSOR_W-1], best_upd})
                > $signed({{(TENSOR_W + 1 - THR_W){1'b0}}, cfg.score_threshold}));

        row_next.left_num   = {{2{cx_upd[TENSOR_W-1]}}, cx_upd, 1'b0}
                            - {{3{w_upd[TENSOR_W-1]}}, w_upd}
                            - {{(NUM_W - PAD_W - 1){1'b0}}, cfg.pad_x, 1'b0};
        row_next.top_num    = {{2{cy_upd[TENSOR_W-1]}}, cy_upd, 1'b0}
                            - {{3{h_upd[TENSOR_W-1]}}, h_upd}
                            - {{(NUM_W - PAD_W - 1){1'b0}}, cfg.pad_y, 1'b0};
        row_next.width_num  = {{2{w_upd[TENSOR_W-1]}}, w_upd, 1'b0};
        row_next.height_num = {{2{h_upd[TENSOR_W-1]}}, h_upd, 1'b0};
        row_next.class_index = cls_upd;
        row_next.confidence  = obj_upd;
    end

    always_comb
    begin
        col_next  = col_reg;
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        w_next    = w_reg;
        h_next    = h_reg;
        obj_next  = obj_reg;
        best_next = best_reg;
        cls_next  = cls_reg;
        row_valid_next = row_valid_reg;
        if (row_valid_reg && row_ready)
        begin
            row_valid_next = 1'b0;
        end
        if (accept)
        begin
            if (tensor.last_in_row)
            begin
                // every row end starts the next row from zero
                col_next  = '0;
                cx_next   = '0;
                cy_next   = '0;
                w_next    = '0;
                h_next    = '0;
                obj_next  = '0;
                best_next = '0;
                cls_next  = '0;
                if (keep)
                begin
                    row_valid_next = 1'b1;
                end
            end
            else
            begin
                col_next  = col_upd;
                cx_next   = cx_upd;
                cy_next   = cy_upd;
                w_next    = w_upd;
                h_next    = h_upd;
                obj_next  = obj_upd;
                best_next = best_upd;
                cls_next  = cls_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            w_reg         <= '0;
            h_reg         <= '0;
            obj_reg       <= '0;
            best_reg      <= '0;
            cls_reg       <= '0;
            row_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            cx_reg        <= cx_next;
            cy_reg        <= cy_next;
            w_reg         <= w_next;
            h_reg         <= h_next;
            obj_reg       <= obj_next;
            best_reg      <= best_next;
            cls_reg       <= cls_next;
            row_valid_reg <= row_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && tensor.last_in_row && keep)
        begin
            row_reg <= row_next;
        end
    end

    assign row_valid = row_valid_reg;
    assign row       = row_reg;

`ifndef ASSERT_OFF
    a_row_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && tensor.last_in_row |=> col_reg == '0 && cls_reg == '0 && best_reg == '0)
        else $error("row state not cleared after row end");

    a_col_advances: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !tensor.last_in_row && col_reg != COL_W'(COL_MAX)
        |=> col_reg == $past(col_reg) + COL_W'(1))
        else $error("column index did not advance");

    a_row_held: assert property (@(posedge clk) disable iff (!rst_n)
        row_valid_reg && !row_ready |=> row_valid_reg && $stable(row_reg))
        else $error("row stage lost or changed while stalled");
`endif

endmodule

### rtl/core/drd_box_math.sv
// Box math: letterbox scale multiply stage, then truncation toward zero and
// saturation into the output register. Depends on drd_pkg, drd_out_if.
module drd_box_math (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [drd_pkg::INV_W-1:0] inverse_scale,
    input  logic                      row_valid,
    input  drd_pkg::drd_row_t         row,
    output logic                      row_ready,
    drd_out_if.source                 box
);
    import drd_pkg::*;

    logic en2, en3;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;

    logic signed [INV_W:0]      scale;
    logic signed [PROD_W-1:0]   left_p_reg, top_p_reg, width_p_reg, height_p_reg;
    logic signed [PROD_W-1:0]   left_p_next, top_p_next, width_p_next, height_p_next;
    logic [CLASS_W-1:0]         cls2_reg;
    logic signed [TENSOR_W-1:0] conf2_reg;

    logic signed [PIX_W-1:0]    left_reg, top_reg, left_next, top_next;
    logic [PIX_W-1:0]           width_reg, height_reg, width_next, height_next;
    logic [CLASS_W-1:0]         cls3_reg;
    logic signed [TENSOR_W-1:0] conf3_reg;

    // whole pixels, rounded toward zero
    function automatic logic signed [PIX_Q_W-1:0] to_pixels(logic signed [PROD_W-1:0] p);
        logic signed [PIX_Q_W-1:0] fl;
        logic                      nz;
        fl = p[PROD_W-1:PIX_SHIFT];
        nz = |p[PIX_SHIFT-1:0];
        return fl + PIX_Q_W'(p[PROD_W-1] && nz);
    endfunction

    function automatic logic [PIX_W-1:0] sat_signed(logic signed [PIX_Q_W-1:0] q);
        logic fits;
        fits = (q[PIX_Q_W-1:PIX_W-1] == '0) || (q[PIX_Q_W-1:PIX_W-1] == '1);
        if (fits)
            return q[PIX_W-1:0];
        else
            return q[PIX_Q_W-1] ? {1'b1, {(PIX_W - 1){1'b0}}} : {1'b0, {(PIX_W - 1){1'b1}}};
    endfunction

    function automatic logic [PIX_W-1:0] sat_unsigned(logic signed [PIX_Q_W-1:0] q);
        if (q[PIX_Q_W-1])
            return '0;
        else if (|q[PIX_Q_W-2:PIX_W])
            return '1;
        else
            return q[PIX_W-1:0];
    endfunction

    assign en3       = !v3_reg || box.ready;
    assign en2       = !v2_reg || en3;
    assign row_ready = en2;

    assign scale = $signed({1'b0, inverse_scale});

    always_comb
    begin
        left_p_next   = row.left_num * scale;
        top_p_next    = row.top_num * scale;
        width_p_next  = row.width_num * scale;
        height_p_next = row.height_num * scale;

        left_next   = sat_signed(to_pixels(left_p_reg));
        top_next    = sat_signed(to_pixels(top_p_reg));
        width_next  = sat_unsigned(to_pixels(width_p_reg));
        height_next = sat_unsigned(to_pixels(height_p_reg));

        v2_next = en2 ? row_valid : v2_reg;
        v3_next = en3 ? v2_reg : v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && row_valid)
        begin
            left_p_reg   <= left_p_next;
            top_p_reg    <= top_p_next;
            width_p_reg  <= width_p_next;
            height_p_reg <= height_p_next;
            cls2_reg     <= row.class_index;
            conf2_reg    <= row.confidence;
        end
        if (en3 && v2_reg)
        begin
            left_reg   <= left_next;
            top_reg    <= top_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            cls3_reg   <= cls2_reg;
            conf3_reg  <= conf2_reg;
        end
    end

    assign box.valid       = v3_reg;
    assign box.box_left    = left_reg;
    assign box.box_top     = top_reg;
    assign box.box_width   = width_reg;
    assign box.box_height  = height_reg;
    assign box.class_index = cls3_reg;
    assign box.confidence  = conf3_reg;

`ifndef ASSERT_OFF
    a_mult_held: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && !en3 |=> v2_reg && $stable(left_p_reg) && $stable(cls2_reg))
        else $error("multiply stage changed while stalled");

    a_mult_moves: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && en3 |=> v3_reg)
        else $error("multiply stage result lost");

    a_box_held: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !box.ready |=> v3_reg && $stable(left_reg) && $stable(conf3_reg))
        else $error("box word changed while stalled");
`endif

endmodule

### rtl/core/detection_row_decoder_core.sv
// Top level of the detection row decoder: configuration registers and the
// row accumulator feeding the box math. Depends on drd_pkg, drd_in_if, drd_out_if.
module detection_row_decoder_core (
    input  logic                            clk,
    input  logic                            rst_n,
    drd_in_if.sink                          tensor,
    drd_out_if.source                       box,
    input  logic                            cfg_write,
    input  logic [drd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [drd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    // Takes one tensor word per clock on tensor while tensor.ready is high:
    // columns 0..3 are centre x, centre y, width and height, column 4
    // objectness, then one score per class; later columns are ignored and a
    // word with last_in_row ends the row. A row whose objectness is at or above
    // the objectness threshold and whose first maximal class score is above the
    // score threshold gives one box on box; other rows give nothing. Words
    // stream at one per cycle while tensor.ready stays high, rows back to back.
    // The box leaves through three registered stages (row register, scale
    // multiply, truncate and saturate) in that order. Each stage advances
    // whenever the stage after it is empty or moving, so tensor.ready drops
    // only when all three stages hold boxes and box.ready is low.
    // Configuration writes (cfg_write, cfg_index, cfg_data, low bits of
    // cfg_data used) take effect at the next edge; write them while no row is
    // in flight. Indexes beyond the register list are ignored.
    import drd_pkg::*;

    drd_cfg_t cfg_reg, cfg_next;

    logic     row_valid;
    logic     row_ready;
    drd_row_t row;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_OBJ_THRESHOLD:   cfg_next.obj_threshold   = cfg_data[THR_W-1:0];
                REG_SCORE_THRESHOLD: cfg_next.score_threshold = cfg_data[THR_W-1:0];
                REG_INVERSE_SCALE:   cfg_next.inverse_scale   = cfg_data[INV_W-1:0];
                REG_PAD_X:           cfg_next.pad_x           = cfg_data[PAD_W-1:0];
                REG_PAD_Y:           cfg_next.pad_y           = cfg_data[PAD_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.obj_threshold   <= OBJ_THRESHOLD_RST;
            cfg_reg.score_threshold <= SCORE_THRESHOLD_RST;
            cfg_reg.inverse_scale   <= INVERSE_SCALE_RST;
            cfg_reg.pad_x           <= '0;
            cfg_reg.pad_y           <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Column capture, argmax and row-end keep test.
    drd_row_acc u_row_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .tensor    (tensor),
        .cfg       (cfg_reg),
        .row_valid (row_valid),
        .row       (row),
        .row_ready (row_ready)
    );

    // Letterbox correction and saturation into the output register.
    drd_box_math u_box_math (
        .clk           (clk),
        .rst_n         (rst_n),
        .inverse_scale (cfg_reg.inverse_scale),
        .row_valid     (row_valid),
        .row           (row),
        .row_ready     (row_ready),
        .box           (box)
    );

endmodule
